[sv/kple_pkg.sv]
package kple_pkg;

  // Default depth of the previous-key store
  localparam int unsigned MAX_KEY_BYTES_DEF = 255;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PFX_W  = 8;
  localparam int unsigned KLEN_W = 12;
  localparam int unsigned SLEN_W = 8;

  // Key length saturation point
  localparam logic [KLEN_W-1:0] KLEN_SAT = 12'd4095;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PREFIX = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_GAP = 1'd1;

  // Reset values of the configuration registers
  localparam logic [PFX_W-1:0] MIN_PREFIX_RST = 8'd4;
  localparam logic [PFX_W-1:0] UPDATE_GAP_RST = 8'd10;

  // Byte handed from the address stage to the compare stage
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              cmp_ok;
    logic [BYTE_W-1:0] key_byte;
    logic [KLEN_W-1:0] klen;
  } kple_byte_t;

endpackage

[sv/kple_ram.sv]
module kple_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read and a write to the same entry return the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/kple_addr.sv]
module kple_addr #(
  parameter int unsigned MAX_KEY_BYTES = kple_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             advance,
  input  logic [kple_pkg::BYTE_W-1:0]      key_byte,
  input  logic                             last_byte,
  output logic                             ram_we,
  output logic [$clog2(MAX_KEY_BYTES)-1:0] ram_addr,
  output logic [kple_pkg::BYTE_W-1:0]      ram_wdata,
  output kple_pkg::kple_byte_t             s1
);

  localparam int unsigned AW = $clog2(MAX_KEY_BYTES);
  localparam logic [kple_pkg::KLEN_W-1:0] MAX_IDX = kple_pkg::KLEN_W'(MAX_KEY_BYTES);

  logic [kple_pkg::KLEN_W-1:0] byte_index_r, byte_index_nxt;
  logic [kple_pkg::SLEN_W-1:0] stored_len_r, stored_len_nxt;
  kple_pkg::kple_byte_t        s1_r, s1_nxt;
  logic [kple_pkg::KLEN_W-1:0] klen;
  logic                        in_store;

  // Position of this byte, key length so far and store bound
  always_comb begin
    in_store = byte_index_r < MAX_IDX;
    klen = (byte_index_r >= kple_pkg::KLEN_SAT) ? kple_pkg::KLEN_SAT
                                                : byte_index_r + 1'b1;
  end

  // Read and overwrite the same entry of the previous key
  assign ram_we    = accept && in_store;
  assign ram_addr  = byte_index_r[AW-1:0];
  assign ram_wdata = key_byte;

  // Advance the byte position and the stored key length
  always_comb begin
    byte_index_nxt = byte_index_r;
    stored_len_nxt = stored_len_r;
    if (accept) begin
      if (last_byte) begin
        byte_index_nxt = '0;
        stored_len_nxt = (klen > MAX_IDX) ? kple_pkg::SLEN_W'(MAX_KEY_BYTES)
                                          : klen[kple_pkg::SLEN_W-1:0];
      end else begin
        byte_index_nxt = klen;
      end
    end
  end

  // Hand the byte to the compare stage, aligned with the read data
  always_comb begin
    s1_nxt = s1_r;
    if (advance) begin
      s1_nxt.valid    = accept;
      s1_nxt.last     = last_byte;
      s1_nxt.cmp_ok   = in_store &&
                        (byte_index_r < {{(kple_pkg::KLEN_W-kple_pkg::SLEN_W){1'b0}},
                                         stored_len_r});
      s1_nxt.key_byte = key_byte;
      s1_nxt.klen     = klen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      stored_len_r <= '0;
      s1_r         <= '0;
    end else begin
      byte_index_r <= byte_index_nxt;
      stored_len_r <= stored_len_nxt;
      s1_r         <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

[sv/kple_match.sv]
module kple_match (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kple_pkg::kple_byte_t            s1,
  input  logic [kple_pkg::BYTE_W-1:0]     rd_byte,
  input  logic [kple_pkg::PFX_W-1:0]      min_prefix,
  input  logic [kple_pkg::PFX_W-1:0]      update_gap,
  input  logic                            out_ready,
  output logic                            advance,
  output logic                            out_valid,
  output logic [kple_pkg::PFX_W-1:0]      prefix_len,
  output logic [kple_pkg::KLEN_W-1:0]     key_len
);

  logic [kple_pkg::PFX_W-1:0]  match_count_r, match_count_nxt;
  logic                        still_r, still_nxt;
  logic [kple_pkg::PFX_W-1:0]  prior_r, prior_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [kple_pkg::PFX_W-1:0]  prefix_len_r, prefix_len_nxt;
  logic [kple_pkg::KLEN_W-1:0] key_len_r, key_len_nxt;
  logic [kple_pkg::PFX_W-1:0]  match_upd;
  logic                        still_upd;
  logic [kple_pkg::PFX_W:0]    prior_plus_gap;
  logic [kple_pkg::PFX_W-1:0]  pfx;
  logic                        emit;

  // Stall only when a finished key cannot leave for the output register
  assign advance = !(s1.valid && s1.last && out_valid_r && !out_ready);
  assign emit    = advance && s1.valid && s1.last;

  // Compare against the previous key's byte at the same position
  always_comb begin
    match_upd = match_count_r;
    still_upd = still_r;
    if (still_r && s1.cmp_ok && (rd_byte == s1.key_byte)) begin
      match_upd = match_count_r + 1'b1;
    end else begin
      still_upd = 1'b0;
    end
  end

  // Apply the minimum and the growth gap rules
  always_comb begin
    prior_plus_gap = {1'b0, prior_r} + {1'b0, update_gap};
    if (match_upd < min_prefix) begin
      pfx = '0;
    end else if ((prior_r != '0) && (match_upd > prior_r) &&
                 ({1'b0, match_upd} < prior_plus_gap)) begin
      pfx = prior_r;
    end else begin
      pfx = match_upd;
    end
  end

  // Update match state and load the output register
  always_comb begin
    match_count_nxt = match_count_r;
    still_nxt       = still_r;
    prior_nxt       = prior_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    prefix_len_nxt  = prefix_len_r;
    key_len_nxt     = key_len_r;
    if (advance && s1.valid) begin
      if (s1.last) begin
        match_count_nxt = '0;
        still_nxt       = 1'b1;
        prior_nxt       = pfx;
      end else begin
        match_count_nxt = match_upd;
        still_nxt       = still_upd;
      end
    end
    if (emit) begin
      out_valid_nxt  = 1'b1;
      prefix_len_nxt = pfx;
      key_len_nxt    = s1.klen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_count_r <= '0;
      still_r       <= 1'b1;
      prior_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      match_count_r <= match_count_nxt;
      still_r       <= still_nxt;
      prior_r       <= prior_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    prefix_len_r <= prefix_len_nxt;
    key_len_r    <= key_len_nxt;
  end

  assign out_valid  = out_valid_r;
  assign prefix_len = prefix_len_r;
  assign key_len    = key_len_r;

endmodule

[sv/key_prefix_length_encoder.sv]
// Front-coding prefix length encoder for a stream of sorted keys.
// Input channel in_*: one key byte per transfer in in_tdata, in_tlast set on
// the final byte of each key. Keys are never empty.
// Result channel out_*: one transfer per key, carrying the prefix length
// shared with the previous key (after the minimum and growth-gap rules) and
// the key length, saturating at 4095.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 = min_prefix, 1 = update_gap); write only while the block is idle.
// Throughput: one byte per cycle while in_tready is high; each accepted byte
// reads its previous-key entry, which is overwritten in the same cycle if in
// the store (read-first). Results go via the s1 and output registers.
// Stalls: with out_tready low, bytes keep flowing until a finished key finds
// the output register still full; then in_tready drops until it drains.
// Reset: rst_n clears the byte position, stored length, match state and the
// previous prefix, and restores min_prefix = 4 and update_gap = 10. The
// key memory is not cleared; only entries already written are ever compared.
module key_prefix_length_encoder #(
  parameter int unsigned MAX_KEY_BYTES = kple_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] key_byte
  input  logic                              in_tlast,  // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata, // [7:0] prefix_len, [19:8] key_len
  input  logic                              cfg_we,
  input  logic [kple_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kple_pkg::PFX_W-1:0]        cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_KEY_BYTES);

  logic [kple_pkg::PFX_W-1:0]  min_prefix_r, min_prefix_nxt;
  logic [kple_pkg::PFX_W-1:0]  update_gap_r, update_gap_nxt;
  logic                        advance;
  logic                        accept;
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [kple_pkg::BYTE_W-1:0] ram_wdata;
  logic [kple_pkg::BYTE_W-1:0] ram_rdata;
  kple_pkg::kple_byte_t        s1;
  logic [kple_pkg::PFX_W-1:0]  prefix_len;
  logic [kple_pkg::KLEN_W-1:0] key_len;

  // Configuration register writes
  always_comb begin
    min_prefix_nxt = min_prefix_r;
    update_gap_nxt = update_gap_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        kple_pkg::CFG_MIN_PREFIX: min_prefix_nxt = cfg_wdata;
        kple_pkg::CFG_UPDATE_GAP: update_gap_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_prefix_r <= kple_pkg::MIN_PREFIX_RST;
      update_gap_r <= kple_pkg::UPDATE_GAP_RST;
    end else begin
      min_prefix_r <= min_prefix_nxt;
      update_gap_r <= update_gap_nxt;
    end
  end

  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  kple_addr #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .advance   (advance),
    .key_byte  (in_tdata),
    .last_byte (in_tlast),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .s1        (s1)
  );

  kple_ram #(
    .WIDTH(kple_pkg::BYTE_W),
    .DEPTH(MAX_KEY_BYTES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  kple_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .rd_byte    (ram_rdata),
    .min_prefix (min_prefix_r),
    .update_gap (update_gap_r),
    .out_ready  (out_tready),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .prefix_len (prefix_len),
    .key_len    (key_len)
  );

  assign out_tdata = {4'b0000, key_len, prefix_len};

endmodule
